// File: rtl/core/hrbc_pkg.sv
// Shared constants and types for the hex record block combiner.
package hrbc_pkg;

    localparam int BLOCK_BYTES = 256;
    localparam int CHUNK_BYTES = 8;
    localparam int ROWS        = BLOCK_BYTES / CHUNK_BYTES;
    localparam int ROW_W       = $clog2(ROWS);
    localparam int LANE_W      = $clog2(CHUNK_BYTES);
    localparam int FILL_W      = $clog2(BLOCK_BYTES + 1);
    localparam int ADDR_W      = 32;
    localparam int COUNT_W     = 8;
    localparam int OFFSET_W    = 8;
    localparam int BYTES_W     = 4;
    localparam int CHUNK_W     = CHUNK_BYTES * 8;
    localparam int S_DATA_W    = 48;
    localparam int S_USER_W    = 2;
    localparam int M_DATA_W    = 112;

    typedef enum logic [0:0]
    {
        ST_IDLE,
        ST_EMIT
    } state_t;

endpackage

// File: rtl/core/hrbc_block_ram.sv
// Block byte store: one row per chunk, byte-lane writes, registered row reads.
module hrbc_block_ram
(
    input  logic                          clk,
    input  logic                          we,
    input  logic [hrbc_pkg::ROW_W-1:0]    waddr,
    input  logic [hrbc_pkg::LANE_W-1:0]   wlane,
    input  logic [7:0]                    wbyte,
    input  logic                          re,
    input  logic [hrbc_pkg::ROW_W-1:0]    raddr,
    output logic [hrbc_pkg::CHUNK_W-1:0]  rdata
);
    import hrbc_pkg::*;

    logic [CHUNK_W-1:0] mem_q [ROWS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_q[waddr][wlane*8 +: 8] <= wbyte;
        end
    end

    // read data holds while no read is issued
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem_q[raddr];
        end
    end

endmodule

// File: rtl/core/hex_record_block_combiner.sv
// Top level: record byte gathering, block bookkeeping and chunk emission.
// An item that closes no block is absorbed in its accept cycle.
// An item that emits a block of F filled bytes gives ceil(F/8) chunks once the FSM
// is in ST_EMIT; the input waits until the last is taken.
// Chunk rate is one per cycle while m_tready holds, set by the single 64-bit row read port.
// Reset clears block state (no open block); store contents stay undefined until written.
module hex_record_block_combiner
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // record_address[31:0], record_count[39:32], data_byte[47:40]
    input  logic [hrbc_pkg::S_DATA_W-1:0]   s_tdata,
    // op[0], first_of_record[1]
    input  logic [hrbc_pkg::S_USER_W-1:0]   s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // block_address[31:0], chunk_offset[39:32], chunk_data[103:40],
    // chunk_bytes[107:104], zero[111:108]
    output logic [hrbc_pkg::M_DATA_W-1:0]   m_tdata,
    output logic                            m_tlast
);
    import hrbc_pkg::*;

    state_t               state_reg, state_next;
    logic [ADDR_W-1:0]    start_reg;
    logic [FILL_W-1:0]    fill_reg;
    logic                 open_reg;

    logic [ADDR_W-1:0]    pend_start_reg;
    logic                 pend_open_reg;
    logic                 pend_write_reg;
    logic [7:0]           pend_byte_reg;

    logic [ROW_W-1:0]     rptr_reg;
    logic                 issue_done_reg;
    logic                 out_valid_reg;
    logic [OFFSET_W-1:0]  out_offset_reg;
    logic [BYTES_W-1:0]   out_bytes_reg;
    logic                 out_last_reg;

    logic                 in_op;
    logic                 in_first;
    logic [ADDR_W-1:0]    in_addr;
    logic [COUNT_W-1:0]   in_count;
    logic [7:0]           in_byte;

    logic [ADDR_W:0]      end_sum;
    logic [ADDR_W:0]      limit_sum;
    logic [ADDR_W:0]      rec_end;
    logic                 cont;
    logic                 has_data;

    logic                 dec_emit;
    logic [ADDR_W-1:0]    dec_start;
    logic                 dec_open;
    logic                 dec_write;
    logic [FILL_W-1:0]    dec_base;

    logic                 accept;
    logic                 commit;
    logic                 rd_issue;

    logic [FILL_W-1:0]    fill_m1;
    logic [ROW_W-1:0]     last_row;
    logic [BYTES_W-1:0]   tail_bytes;
    logic [BYTES_W-1:0]   row_bytes;

    logic                 ram_we;
    logic [ROW_W-1:0]     ram_waddr;
    logic [LANE_W-1:0]    ram_wlane;
    logic [7:0]           ram_wbyte;
    logic [CHUNK_W-1:0]   ram_rdata;
    logic [CHUNK_W-1:0]   chunk_masked;

    assign in_op    = s_tuser[0];
    assign in_first = s_tuser[1];
    assign in_addr  = s_tdata[31:0];
    assign in_count = s_tdata[39:32];
    assign in_byte  = s_tdata[47:40];

    // continue test, computed without wrap
    assign end_sum   = {1'b0, start_reg} + {{(ADDR_W + 1 - FILL_W){1'b0}}, fill_reg};
    assign limit_sum = {1'b0, start_reg} + (ADDR_W + 1)'(BLOCK_BYTES);
    assign rec_end   = {1'b0, in_addr} + {{(ADDR_W + 1 - COUNT_W){1'b0}}, in_count};
    assign cont      = open_reg && ({1'b0, in_addr} == end_sum) && (rec_end <= limit_sum);
    assign has_data  = open_reg && (fill_reg != '0);

    always_comb
    begin
        dec_emit  = 1'b0;
        dec_start = start_reg;
        dec_open  = open_reg;
        dec_write = 1'b0;
        dec_base  = fill_reg;
        if (in_op)
        begin
            dec_emit  = has_data;
            dec_start = '0;
            dec_open  = 1'b0;
            dec_base  = '0;
        end
        else if (in_first && !cont)
        begin
            dec_emit  = has_data;
            dec_start = in_addr;
            dec_open  = 1'b1;
            dec_base  = '0;
            dec_write = 1'b1;
        end
        else if (open_reg)
        begin
            dec_write = 1'b1;
            // full block: emit it and roll over to the next block address
            if (fill_reg == FILL_W'(BLOCK_BYTES))
            begin
                dec_emit  = 1'b1;
                dec_start = start_reg + ADDR_W'(BLOCK_BYTES);
                dec_base  = '0;
            end
        end
    end

    assign fill_m1    = fill_reg - 1'b1;
    assign last_row   = fill_m1[LANE_W +: ROW_W];
    assign tail_bytes = (fill_reg[LANE_W-1:0] == '0) ? BYTES_W'(CHUNK_BYTES)
                                                      : BYTES_W'(fill_reg[LANE_W-1:0]);
    assign row_bytes  = (rptr_reg == last_row) ? tail_bytes : BYTES_W'(CHUNK_BYTES);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && dec_emit)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs and strobes
    always_comb
    begin
        s_tready = 1'b0;
        rd_issue = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            ST_EMIT:
            begin
                rd_issue = !issue_done_reg && (!out_valid_reg || m_tready);
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    assign accept = s_tvalid && s_tready;
    assign commit = out_valid_reg && m_tready && out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            start_reg      <= '0;
            fill_reg       <= '0;
            open_reg       <= 1'b0;
            issue_done_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            rptr_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept && !dec_emit)
            begin
                start_reg <= dec_start;
                open_reg  <= dec_open;
                fill_reg  <= dec_base + FILL_W'(dec_write);
            end
            else if (commit)
            begin
                start_reg <= pend_start_reg;
                open_reg  <= pend_open_reg;
                fill_reg  <= FILL_W'(pend_write_reg);
            end

            if (accept && dec_emit)
            begin
                rptr_reg       <= '0;
                issue_done_reg <= 1'b0;
            end
            else if (rd_issue)
            begin
                rptr_reg       <= rptr_reg + 1'b1;
                issue_done_reg <= (rptr_reg == last_row);
            end

            if (rd_issue)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // hold the request that caused the emission until the block has drained; register chunk offset, bytes, last
    always_ff @(posedge clk)
    begin
        if (accept && dec_emit)
        begin
            pend_start_reg <= dec_start;
            pend_open_reg  <= dec_open;
            pend_write_reg <= dec_write;
            pend_byte_reg  <= in_byte;
        end
        if (rd_issue)
        begin
            out_offset_reg <= OFFSET_W'({rptr_reg, {LANE_W{1'b0}}});
            out_bytes_reg  <= row_bytes;
            out_last_reg   <= (rptr_reg == last_row);
        end
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = dec_base[LANE_W +: ROW_W];
        ram_wlane = dec_base[LANE_W-1:0];
        ram_wbyte = in_byte;
        if (commit)
        begin
            ram_we    = pend_write_reg;
            ram_waddr = '0;
            ram_wlane = '0;
            ram_wbyte = pend_byte_reg;
        end
        else if (accept && !dec_emit)
        begin
            ram_we = dec_write;
        end
    end

    hrbc_block_ram u_block_ram
    (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wlane (ram_wlane),
        .wbyte (ram_wbyte),
        .re    (rd_issue),
        .raddr (rptr_reg),
        .rdata (ram_rdata)
    );

    // zero the lanes past the valid byte count
    always_comb
    begin
        for (int k = 0; k < CHUNK_BYTES; k++)
        begin
            chunk_masked[k*8 +: 8] = (BYTES_W'(k) < out_bytes_reg) ? ram_rdata[k*8 +: 8] : 8'h00;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(M_DATA_W - ADDR_W - OFFSET_W - CHUNK_W - BYTES_W){1'b0}},
                       out_bytes_reg, chunk_masked, out_offset_reg, start_reg};

    a_out_only_emit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> state_reg == ST_EMIT)
        else $error("chunk presented outside emission");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(BLOCK_BYTES))
        else $error("block fill past block size");

    a_closed_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !open_reg |-> fill_reg == '0)
        else $error("closed block holds bytes");

    a_last_returns: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> (state_reg == ST_IDLE && !m_tvalid))
        else $error("emission did not end after last chunk");

endmodule

// File: tb/tb_hex_record_block_combiner.sv
// Self-checking testbench for the hex record block combiner.
`timescale 1ns / 100ps

module tb_hex_record_block_combiner;

    import hrbc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_GAP     = 60;

    typedef enum logic [0:0]
    {
        OP_DATA,
        OP_FLUSH
    } op_t;

    typedef struct packed
    {
        logic [ADDR_W-1:0]   addr;
        logic [OFFSET_W-1:0] offset;
        logic [CHUNK_W-1:0]  data;
        logic [BYTES_W-1:0]  nbytes;
        logic                last;
    } chunk_t;

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic [S_USER_W-1:0] s_tuser  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tlast;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;
    int mismatches     = 0;
    int cycle_count    = 0;

    // Block state as seen from the record stream
    logic [7:0]        blk_bytes [BLOCK_BYTES];
    logic [ADDR_W-1:0] blk_start = '0;
    logic [FILL_W-1:0] blk_fill  = '0;
    logic              blk_open  = 1'b0;

    chunk_t pending_chunks [$];

    hex_record_block_combiner u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d chunks outstanding", $time,
                     pending_chunks.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // Receiver: a long hold-off takes priority over random stalls
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic void split_block_into_chunks();
        int     pos;
        int     take;
        int     k;
        chunk_t c;
        if (!blk_open)
            return;
        pos = 0;
        while (pos < blk_fill)
        begin
            take = blk_fill - pos;
            if (take > CHUNK_BYTES)
                take = CHUNK_BYTES;
            c.data = '0;
            for (k = 0; k < take; k++)
                c.data[8*k +: 8] = blk_bytes[pos + k];
            c.addr   = blk_start;
            c.offset = pos[OFFSET_W-1:0];
            c.nbytes = take[BYTES_W-1:0];
            c.last   = (pos + take >= blk_fill);
            pending_chunks.push_back(c);
            pos += take;
        end
    endfunction

    function automatic void open_block_at(input logic [ADDR_W-1:0] addr);
        blk_start = addr;
        blk_fill  = '0;
        blk_open  = 1'b1;
    endfunction

    function automatic void absorb_item(input op_t op, input logic first,
                                        input logic [ADDR_W-1:0] addr,
                                        input logic [COUNT_W-1:0] cnt,
                                        input logic [7:0] data);
        logic [ADDR_W:0] fill_end;
        logic [ADDR_W:0] block_end;
        logic            extend;
        if (op == OP_FLUSH)
        begin
            split_block_into_chunks();
            blk_open  = 1'b0;
            blk_start = '0;
            blk_fill  = '0;
            return;
        end
        if (first)
        begin
            // compare in 33 bits so a record never continues across the wrap
            fill_end  = {1'b0, blk_start} + blk_fill;
            block_end = {1'b0, blk_start} + BLOCK_BYTES;
            extend    = blk_open && ({1'b0, addr} == fill_end) &&
                        ({1'b0, addr} + cnt <= block_end);
            if (!extend)
            begin
                split_block_into_chunks();
                open_block_at(addr);
            end
        end
        else if (!blk_open)
        begin
            return;
        end
        if (blk_fill >= BLOCK_BYTES)
        begin
            split_block_into_chunks();
            open_block_at(blk_start + ADDR_W'(BLOCK_BYTES));
        end
        blk_bytes[blk_fill[7:0]] = data;
        blk_fill++;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin
        chunk_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_chunks.size() == 0)
            begin
                $display("%0t: unexpected chunk, expected none, actual %h last %b",
                         $time, m_tdata, m_tlast);
                mismatches++;
            end
            else
            begin
                want = pending_chunks.pop_front();
                check_field("block_address", want.addr, m_tdata[31:0]);
                check_field("chunk_offset", want.offset, m_tdata[39:32]);
                check_field("chunk_data", want.data, m_tdata[103:40]);
                check_field("chunk_bytes", want.nbytes, m_tdata[107:104]);
                check_field("pad", 64'd0, m_tdata[111:108]);
                check_field("last_chunk", want.last, m_tlast);
            end
        end
    end

    task automatic send_item(input op_t op, input logic first,
                             input logic [ADDR_W-1:0] addr,
                             input logic [COUNT_W-1:0] cnt,
                             input logic [7:0] data);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {data, cnt, addr};
        s_tuser  <= {first, op};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        absorb_item(op, first, addr, cnt, data);
        @(negedge clk);
    endtask

    // One record: a first byte, then the rest with junk in the ignored fields
    task automatic send_record(input logic [ADDR_W-1:0] addr,
                               input logic [COUNT_W-1:0] cnt, input int nbytes);
        send_item(OP_DATA, 1'b1, addr, cnt, 8'($urandom));
        repeat (nbytes - 1)
            send_item(OP_DATA, 1'b0, $urandom, 8'($urandom), 8'($urandom));
    endtask

    task automatic finish_phase();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending_chunks.size() != 0)
            @(negedge clk);
    endtask

    task automatic test_directed_cases();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        // flush and stray byte with nothing open
        send_item(OP_FLUSH, 1'b0, '0, '0, 8'h00);
        send_item(OP_DATA, 1'b0, '1, '1, 8'hFF);
        // zero count record that still takes two bytes, then an exact follow-on
        send_item(OP_DATA, 1'b1, 32'h0000_0000, 8'h00, 8'h00);
        send_item(OP_DATA, 1'b0, '1, '1, 8'hFF);
        send_record(32'h0000_0002, 8'd3, 3);
        send_item(OP_DATA, 1'b1, 32'hFFFF_FFFF, 8'hFF, 8'hA5);
        // top of the address space does not continue into address zero
        send_item(OP_DATA, 1'b1, 32'h0000_0000, 8'h01, 8'h5A);
        send_item(OP_FLUSH, 1'b1, '1, '1, 8'hFF);
        send_item(OP_FLUSH, 1'b0, '0, '0, 8'h00);
        // record ending exactly at the block end continues, one byte past does not
        send_record(32'h0000_0100, 8'd8, 8);
        send_record(32'h0000_0108, 8'd248, 2);
        send_record(32'h0000_010A, 8'd247, 1);
        send_item(OP_DATA, 1'b1, 32'h0000_010B, 8'h80, 8'h3C);
        send_item(OP_FLUSH, 1'b0, '0, '0, 8'h00);
        finish_phase();
    endtask

    task automatic test_block_full();
        send_idle_pct  = 35;
        recv_stall_pct = 35;
        // overflow near the top: the next block start wraps to a low address
        send_record(32'hFFFF_FF80, 8'd255, 257);
        send_item(OP_FLUSH, 1'b0, '0, '0, 8'h00);
        finish_phase();
    endtask

    task automatic test_input_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 300;
        send_record($urandom, 8'd30, 30);
        send_record($urandom, 8'd4, 4);
        send_item(OP_FLUSH, 1'b0, '0, '0, 8'h00);
        finish_phase();
    endtask

    task automatic test_random_records(input int idle_pct, input int stall_pct,
                                       input int n_items);
        int                 sent;
        int                 pick;
        int                 nbytes;
        int                 room;
        logic [ADDR_W-1:0]  addr;
        logic [COUNT_W-1:0] cnt;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < n_items)
        begin
            pick = $urandom_range(99);
            if (pick < 7)
            begin
                send_item(OP_FLUSH, 1'($urandom), $urandom, 8'($urandom), 8'($urandom));
                sent++;
            end
            else if (pick < 12)
            begin
                if (blk_open)
                    sent++;
                send_item(OP_DATA, 1'b0, $urandom, 8'($urandom), 8'($urandom));
            end
            else
            begin
                room = BLOCK_BYTES - int'(blk_fill);
                if (blk_open && $urandom_range(99) < 55)
                begin
                    addr = blk_start + blk_fill;
                    cnt  = (room == 0) ? 8'd0 : 8'($urandom_range(1, (room < 24) ? room : 24));
                end
                else
                begin
                    addr = ($urandom_range(3) == 0) ? (32'hFFFF_FF00 | $urandom_range(255))
                                                    : $urandom;
                    cnt  = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(1, 24));
                end
                // mostly honor the count, sometimes send a different number of bytes
                if ($urandom_range(4) == 0)
                    nbytes = $urandom_range(1, 30);
                else
                    nbytes = (cnt == 0) ? 1 : int'(cnt);
                if (nbytes > 40)
                    nbytes = 40;
                send_record(addr, cnt, nbytes);
                sent += nbytes;
            end
        end
        send_item(OP_FLUSH, 1'b0, '0, '0, 8'h00);
        finish_phase();
    endtask

    initial
    begin
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed_cases();
        test_block_full();
        test_input_backpressure();
        test_random_records(0, 0, 30);
        test_random_records(86, 0, 30);
        test_random_records(0, 86, 30);
        test_random_records(35, 35, 30);
        repeat (40) @(negedge clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
